// ===== hw/rtl/cscan_pkg.sv =====
package cscan_pkg;

  localparam int QUEUE_DEPTH       = 16;
  localparam int SECTORS_PER_TRACK = 16;
  localparam int MAX_RUN           = 31;
  localparam int FIFO_DEPTH        = 2;

  localparam int TRACK_W  = 10;
  localparam int SECTOR_W = 4;
  localparam int COUNT_W  = 5;
  localparam int TAG_W    = 8;
  localparam int CFG_W    = 11;

  localparam int IDX_W      = $clog2(QUEUE_DEPTH);
  localparam int USED_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [CFG_W-1:0] DISK_TRACKS_RESET = CFG_W'(16);

  typedef enum logic [0:0] {
    OP_ENQUEUE  = 1'b0,
    OP_DISPATCH = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    KIND_ACCEPT  = 3'd0,
    KIND_INVALID = 3'd1,
    KIND_FULL    = 3'd2,
    KIND_SEEK    = 3'd3,
    KIND_READ    = 3'd4,
    KIND_WRITE   = 3'd5,
    KIND_IDLE    = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_TAIL,
    ST_DONE,
    ST_SEEK,
    ST_XFER
  } back_state_e;

  // A stored request, as kept in the request memory.
  typedef struct packed {
    logic [TAG_W-1:0]    tag;
    logic                is_write;
    logic [COUNT_W-1:0]  count;
    logic [SECTOR_W-1:0] first;
    logic [TRACK_W-1:0]  track;
  } request_t;

  // A classified item passed from the front end to the back end.
  typedef struct packed {
    op_e      op;
    logic     invalid;
    request_t req;
  } item_t;

endpackage

// ===== hw/rtl/cscan_req_if.sv =====
interface cscan_req_if;

  logic                               valid;
  logic                               ready;
  cscan_pkg::op_e                     op;
  logic [cscan_pkg::TRACK_W-1:0]      req_track;
  logic [cscan_pkg::SECTOR_W-1:0]     req_first_sector;
  logic [cscan_pkg::COUNT_W-1:0]      req_sector_count;
  logic                               req_is_write;
  logic [cscan_pkg::TAG_W-1:0]        req_tag;

  modport source (
    output valid, op, req_track, req_first_sector, req_sector_count, req_is_write,
           req_tag,
    input  ready
  );

  modport sink (
    input  valid, op, req_track, req_first_sector, req_sector_count, req_is_write,
           req_tag,
    output ready
  );

endinterface

// ===== hw/rtl/cscan_res_if.sv =====
interface cscan_res_if;

  logic                           valid;
  logic                           ready;
  cscan_pkg::kind_e               kind;
  logic [cscan_pkg::TRACK_W-1:0]  cmd_track;
  logic [cscan_pkg::SECTOR_W-1:0] cmd_sector;
  logic [cscan_pkg::TAG_W-1:0]    cmd_tag;
  logic                           last;

  modport source (
    output valid, kind, cmd_track, cmd_sector, cmd_tag, last,
    input  ready
  );

  modport sink (
    input  valid, kind, cmd_track, cmd_sector, cmd_tag, last,
    output ready
  );

endinterface

// ===== hw/rtl/cscan_front.sv =====
module cscan_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cscan_pkg::CFG_W-1:0]  cfg_wdata_i,
  cscan_req_if.sink                    req,
  output cscan_pkg::item_t             item_o,
  output logic                         item_valid_o,
  input  logic                         item_ready_i
);
  import cscan_pkg::*;

  logic [CFG_W-1:0] disk_tracks_q;
  logic [5:0]       span;
  logic [CFG_W-1:0] end_track;
  logic             invalid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disk_tracks_q <= DISK_TRACKS_RESET;
    end else if (cfg_we_i) begin
      disk_tracks_q <= cfg_wdata_i;
    end
  end

  // The last track touched is the start track plus the number of track
  // boundaries that the run crosses.
  assign span = 6'(req.req_first_sector) + 6'(req.req_sector_count) - 6'd1;

  always_comb begin
    if (req.req_sector_count == '0) begin
      end_track = CFG_W'(req.req_track);
    end else begin
      end_track = CFG_W'(req.req_track) + CFG_W'(span / SECTORS_PER_TRACK);
    end
    invalid = (int'(req.req_first_sector) >= SECTORS_PER_TRACK) ||
              (int'(req.req_sector_count) > MAX_RUN) ||
              (end_track >= disk_tracks_q);
  end

  assign item_o.op           = req.op;
  assign item_o.invalid      = invalid;
  assign item_o.req.track    = req.req_track;
  assign item_o.req.first    = req.req_first_sector;
  assign item_o.req.count    = req.req_sector_count;
  assign item_o.req.is_write = req.req_is_write;
  assign item_o.req.tag      = req.req_tag;
  assign item_valid_o        = req.valid;
  assign req.ready           = item_ready_i;

endmodule

// ===== hw/rtl/cscan_fifo.sv =====
module cscan_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cscan_pkg::item_t  in_item_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output cscan_pkg::item_t  out_item_o,
  output logic              out_valid_o,
  input  logic              out_ready_i
);
  import cscan_pkg::*;

  item_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q;
  logic [FIFO_PTR_W-1:0] rd_ptr_q;
  logic [FIFO_CNT_W-1:0] cnt_q;
  logic                  push;
  logic                  pop;

  assign in_ready_o  = (cnt_q != FIFO_CNT_W'(FIFO_DEPTH));
  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_fill_tracks_push : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue fill level did not follow a lone push");

endmodule

// ===== hw/rtl/cscan_back.sv =====
module cscan_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cscan_pkg::item_t  item_i,
  input  logic              item_valid_i,
  output logic              item_ready_o,
  cscan_res_if.source       res
);
  import cscan_pkg::*;

  back_state_e state_q, state_d;
  item_t       cur_q;

  // Request store
  request_t          mem [QUEUE_DEPTH];
  request_t          rd_q;
  logic              valid_q [QUEUE_DEPTH];
  logic              ahead_q [QUEUE_DEPTH];
  logic [IDX_W-1:0]  age_q [QUEUE_DEPTH];
  logic [USED_W-1:0] used_q;
  logic [TRACK_W-1:0] arm_q;

  // Scan
  logic [IDX_W-1:0] idx_q;
  logic             pend_q;
  logic             cv_q;
  logic             ca_q;
  logic [IDX_W-1:0] cg_q;
  logic [IDX_W-1:0] ci_q;
  logic             best_found_q;
  logic [IDX_W-1:0] best_idx_q;
  logic             best_ahead_q;
  logic [IDX_W-1:0] best_age_q;
  request_t         best_req_q;
  logic             better;

  // Transfer sequencing
  logic [SECTOR_W-1:0] sec_q;
  logic [COUNT_W-1:0]  rem_q;
  logic [TRACK_W-1:0]  trk_q;
  logic                need_seek_q;

  // Result register
  logic                res_v_q;
  kind_e               res_kind_q;
  logic [TRACK_W-1:0]  res_track_q;
  logic [SECTOR_W-1:0] res_sector_q;
  logic [TAG_W-1:0]    res_tag_q;
  logic                res_last_q;

  logic                can_load;
  logic                load;
  kind_e               ld_kind;
  logic [TRACK_W-1:0]  ld_track;
  logic [SECTOR_W-1:0] ld_sector;
  logic [TAG_W-1:0]    ld_tag;
  logic                ld_last;
  logic                enq_write;
  logic                commit;
  logic                full;
  logic                free_found;
  logic [IDX_W-1:0]    free_idx;

  assign can_load = !res_v_q || res.ready;
  assign full     = (used_q == USED_W'(QUEUE_DEPTH));

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (!valid_q[i] && !free_found) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // Ahead entries beat behind ones; then the lower track, then the older entry.
  assign better = cv_q && (!best_found_q || (ca_q && !best_ahead_q) ||
                  ((ca_q == best_ahead_q) &&
                   ((rd_q.track < best_req_q.track) ||
                    ((rd_q.track == best_req_q.track) && (cg_q < best_age_q)))));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    item_ready_o = 1'b0;
    load         = 1'b0;
    ld_kind      = KIND_IDLE;
    ld_track     = '0;
    ld_sector    = '0;
    ld_tag       = '0;
    ld_last      = 1'b1;
    enq_write    = 1'b0;
    commit       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (cur_q.op == OP_DISPATCH) begin
          state_d = ST_SCAN;
        end else if (can_load) begin
          load   = 1'b1;
          ld_tag = cur_q.req.tag;
          if (cur_q.invalid) begin
            ld_kind = KIND_INVALID;
          end else if (full) begin
            ld_kind = KIND_FULL;
          end else begin
            ld_kind   = KIND_ACCEPT;
            enq_write = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (idx_q == IDX_W'(QUEUE_DEPTH - 1)) begin
          state_d = ST_TAIL;
        end
      end
      ST_TAIL: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!best_found_q) begin
          if (can_load) begin
            load    = 1'b1;
            ld_kind = KIND_IDLE;
            state_d = ST_IDLE;
          end
        end else begin
          commit  = 1'b1;
          state_d = ST_SEEK;
        end
      end
      ST_SEEK: begin
        if (can_load) begin
          load     = 1'b1;
          ld_kind  = KIND_SEEK;
          ld_track = best_req_q.track;
          ld_tag   = best_req_q.tag;
          ld_last  = (best_req_q.count == '0);
          state_d  = (best_req_q.count == '0) ? ST_IDLE : ST_XFER;
        end
      end
      ST_XFER: begin
        if (can_load) begin
          load   = 1'b1;
          ld_tag = best_req_q.tag;
          if (need_seek_q) begin
            ld_kind  = KIND_SEEK;
            ld_track = trk_q;
            ld_last  = 1'b0;
          end else begin
            ld_kind   = best_req_q.is_write ? KIND_WRITE : KIND_READ;
            ld_sector = sec_q;
            ld_last   = (rem_q == COUNT_W'(1));
            if (rem_q == COUNT_W'(1)) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Request memory: one write port, one registered read port driven by the scan.
  always_ff @(posedge clk_i) begin
    if (enq_write) begin
      mem[free_idx] <= cur_q.req;
    end
    rd_q <= mem[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        valid_q[i] <= 1'b0;
      end
      used_q       <= '0;
      arm_q        <= '0;
      idx_q        <= '0;
      pend_q       <= 1'b0;
      best_found_q <= 1'b0;
      res_v_q      <= 1'b0;
    end else begin
      if (state_q == ST_EXEC) begin
        idx_q        <= '0;
        pend_q       <= 1'b0;
        best_found_q <= 1'b0;
      end
      if (state_q == ST_SCAN) begin
        idx_q  <= idx_q + 1'b1;
        pend_q <= 1'b1;
      end
      if (state_q == ST_TAIL) begin
        pend_q <= 1'b0;
      end
      if ((state_q == ST_SCAN || state_q == ST_TAIL) && pend_q && better) begin
        best_found_q <= 1'b1;
      end
      if (enq_write) begin
        valid_q[free_idx] <= 1'b1;
        used_q            <= used_q + 1'b1;
      end
      if (commit) begin
        valid_q[best_idx_q] <= 1'b0;
        used_q              <= used_q - 1'b1;
        arm_q               <= best_req_q.track;
      end
      if (load) begin
        res_v_q <= 1'b1;
      end else if (res.ready) begin
        res_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && item_valid_i) begin
      cur_q <= item_i;
    end
    if (state_q == ST_SCAN) begin
      cv_q <= valid_q[idx_q];
      ca_q <= ahead_q[idx_q];
      cg_q <= age_q[idx_q];
      ci_q <= idx_q;
    end
    if ((state_q == ST_SCAN || state_q == ST_TAIL) && pend_q && better) begin
      best_idx_q   <= ci_q;
      best_ahead_q <= ca_q;
      best_age_q   <= cg_q;
      best_req_q   <= rd_q;
    end
    if (enq_write) begin
      ahead_q[free_idx] <= (arm_q <= cur_q.req.track);
      age_q[free_idx]   <= used_q[IDX_W-1:0];
    end
    if (commit) begin
      // Entries younger than the served one move up by one place.
      for (int j = 0; j < QUEUE_DEPTH; j++) begin
        if (valid_q[j] && (age_q[j] > best_age_q)) begin
          age_q[j] <= age_q[j] - 1'b1;
        end
      end
      sec_q       <= best_req_q.first;
      rem_q       <= best_req_q.count;
      trk_q       <= best_req_q.track;
      need_seek_q <= 1'b0;
    end
    if (state_q == ST_XFER && can_load) begin
      if (need_seek_q) begin
        need_seek_q <= 1'b0;
      end else begin
        rem_q <= rem_q - 1'b1;
        if (sec_q == SECTOR_W'(SECTORS_PER_TRACK - 1)) begin
          sec_q       <= '0;
          trk_q       <= trk_q + 1'b1;
          need_seek_q <= 1'b1;
        end else begin
          sec_q <= sec_q + 1'b1;
        end
      end
    end
    if (load) begin
      res_kind_q   <= ld_kind;
      res_track_q  <= ld_track;
      res_sector_q <= ld_sector;
      res_tag_q    <= ld_tag;
      res_last_q   <= ld_last;
    end
  end

  assign res.valid      = res_v_q;
  assign res.kind       = res_kind_q;
  assign res.cmd_track  = res_track_q;
  assign res.cmd_sector = res_sector_q;
  assign res.cmd_tag    = res_tag_q;
  assign res.last       = res_last_q;

  a_single_results_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_v_q && (res_kind_q == KIND_ACCEPT || res_kind_q == KIND_INVALID ||
                res_kind_q == KIND_FULL || res_kind_q == KIND_IDLE) |-> res_last_q)
    else $error("single-result item delivered without its last flag");

  a_xfer_has_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_XFER |-> rem_q != '0)
    else $error("transfer sequencer running with no sectors left");

  a_commit_frees_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> used_q == $past(used_q) - 1'b1)
    else $error("dispatch did not release exactly one entry");

endmodule

// ===== hw/rtl/cscan_disk_request_scheduler_top.sv =====
// Enqueue: the back end registers the item, then loads its result; it takes no new item
// until it is back in idle. Dispatch: the back end reads the sixteen entries of the request
// memory one per cycle, passes the tail and done states, then loads an idle result or a seek,
// then one command per cycle while the receiver takes them.
// A two-entry queue parts the front end from the back end; the result register frees the back.
// Reset: store empty, arm at track 0, disk_tracks at 16; no clearing pass is needed.
module cscan_disk_request_scheduler_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [cscan_pkg::CFG_W-1:0] cfg_wdata_i,
  cscan_req_if.sink                   req_i,
  cscan_res_if.source                 res_o
);
  import cscan_pkg::*;

  item_t front_item;
  logic  front_valid;
  logic  front_ready;
  item_t back_item;
  logic  back_valid;
  logic  back_ready;

  cscan_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req          (req_i),
    .item_o       (front_item),
    .item_valid_o (front_valid),
    .item_ready_i (front_ready)
  );

  cscan_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (front_item),
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .out_item_o  (back_item),
    .out_valid_o (back_valid),
    .out_ready_i (back_ready)
  );

  cscan_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (back_item),
    .item_valid_i (back_valid),
    .item_ready_o (back_ready),
    .res          (res_o)
  );

endmodule

// ===== tb/cscan_sched_check_pkg.sv =====
`timescale 1ns / 100ps

package cscan_sched_check_pkg;

  import cscan_pkg::*;

  typedef struct packed {
    kind_e               kind;
    logic [TRACK_W-1:0]  track;
    logic [SECTOR_W-1:0] sector;
    logic [TAG_W-1:0]    tag;
    logic                last;
  } disk_cmd_t;

  // Keeps its own copy of the request store and the arm, and turns every accepted item
  // into the commands that the scheduler ought to issue for it.
  class disk_schedule;

    logic [CFG_W-1:0]   disk_tracks;
    bit                 slot_busy[QUEUE_DEPTH];
    bit                 slot_ahead[QUEUE_DEPTH];
    request_t           slot_req[QUEUE_DEPTH];
    int unsigned        slot_rank[QUEUE_DEPTH];
    logic [TRACK_W-1:0] arm_track;
    disk_cmd_t          pending_cmds[$];
    int unsigned        mismatches;

    function new();
      disk_tracks = DISK_TRACKS_RESET;
      arm_track   = '0;
      mismatches  = 0;
      foreach (slot_busy[i]) begin
        slot_busy[i] = 1'b0;
      end
    endfunction

    function void set_tracks(logic [CFG_W-1:0] value);
      disk_tracks = value;
    endfunction

    function int unsigned pending();
      return pending_cmds.size();
    endfunction

    function void emit(kind_e kind, int unsigned track, int unsigned sector,
                       logic [TAG_W-1:0] tag, bit last);
      disk_cmd_t c;
      c.kind   = kind;
      c.track  = TRACK_W'(track);
      c.sector = SECTOR_W'(sector);
      c.tag    = tag;
      c.last   = last;
      pending_cmds.push_back(c);
    endfunction

    function void enqueue(request_t r);
      int unsigned end_track;
      int unsigned used;
      int          slot;
      end_track = int'(r.track);
      used      = 0;
      slot      = -1;
      if (r.count != 0) begin
        end_track = int'(r.track) + (int'(r.first) + int'(r.count) - 1) / SECTORS_PER_TRACK;
      end
      if (int'(r.first) >= SECTORS_PER_TRACK || int'(r.count) > MAX_RUN ||
          end_track >= int'(disk_tracks)) begin
        emit(KIND_INVALID, 0, 0, r.tag, 1'b1);
        return;
      end
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (slot_busy[i]) begin
          used++;
        end else if (slot < 0) begin
          slot = i;
        end
      end
      if (slot < 0) begin
        emit(KIND_FULL, 0, 0, r.tag, 1'b1);
        return;
      end
      slot_busy[slot]  = 1'b1;
      slot_ahead[slot] = (arm_track <= r.track);
      slot_req[slot]   = r;
      slot_rank[slot]  = used;
      emit(KIND_ACCEPT, 0, 0, r.tag, 1'b1);
    endfunction

    // Lowest track on the given side; among equal tracks the one stored first.
    function int lowest_on_side(bit ahead);
      int best;
      best = -1;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (!slot_busy[i] || slot_ahead[i] != ahead) begin
          continue;
        end
        if (best < 0 || slot_req[i].track < slot_req[best].track ||
            (slot_req[i].track == slot_req[best].track && slot_rank[i] < slot_rank[best])) begin
          best = i;
        end
      end
      return best;
    endfunction

    function void dispatch();
      int          sel;
      request_t    r;
      int unsigned s;
      sel = lowest_on_side(1'b1);
      if (sel < 0) begin
        sel = lowest_on_side(1'b0);
      end
      if (sel < 0) begin
        emit(KIND_IDLE, 0, 0, '0, 1'b1);
        return;
      end
      r = slot_req[sel];
      slot_busy[sel] = 1'b0;
      for (int j = 0; j < QUEUE_DEPTH; j++) begin
        if (slot_busy[j] && slot_rank[j] > slot_rank[sel]) begin
          slot_rank[j]--;
        end
      end
      arm_track = r.track;
      emit(KIND_SEEK, r.track, 0, r.tag, r.count == 0);
      for (int unsigned i = 0; i < r.count; i++) begin
        s = int'(r.first) + i;
        // Wrapping past the end of a track costs a seek to the next one.
        if (i != 0 && s % SECTORS_PER_TRACK == 0) begin
          emit(KIND_SEEK, int'(r.track) + s / SECTORS_PER_TRACK, 0, r.tag, 1'b0);
        end
        emit(r.is_write ? KIND_WRITE : KIND_READ, 0, s % SECTORS_PER_TRACK, r.tag,
             i + 1 == r.count);
      end
    endfunction

    function void take_item(op_e op, request_t r);
      if (op == OP_ENQUEUE) begin
        enqueue(r);
      end else begin
        dispatch();
      end
    endfunction

    function void compare_command(disk_cmd_t got);
      disk_cmd_t want;
      if (pending_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected command: kind=%s track=%0d sector=%0d tag=%0d last=%0d",
                   got.kind.name(), got.track, got.sector, got.tag, got.last);
        end
        return;
      end
      want = pending_cmds.pop_front();
      if (got.kind !== want.kind || got.track !== want.track || got.sector !== want.sector ||
          got.tag !== want.tag || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("command mismatch: expected kind=%s track=%0d sector=%0d tag=%0d last=%0d",
                   want.kind.name(), want.track, want.sector, want.tag, want.last);
          $display("                  actual   kind=%s track=%0d sector=%0d tag=%0d last=%0d",
                   got.kind.name(), got.track, got.sector, got.tag, got.last);
        end
      end
    endfunction

  endclass

endpackage

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  import cscan_pkg::*;
  import cscan_sched_check_pkg::*;

  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned PHASE_ITEMS   = 55;
  localparam int unsigned NUM_PHASES    = 7;
  localparam int unsigned SETTLE_CYCLES = 40;

  localparam logic [CFG_W-1:0] TRACK_PLAN [NUM_PHASES] = '{
    CFG_W'(1024), CFG_W'(1), CFG_W'(40), CFG_W'(0), CFG_W'(2047), CFG_W'(300), CFG_W'(16)
  };

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  int unsigned tx_gap_pct;
  int unsigned rx_gap_pct;
  bit          hold_req;
  bit          hold_taken;
  int unsigned hold_left;
  int unsigned stall_cycles;
  int unsigned sent;

  disk_schedule sched;

  cscan_req_if req_ch ();
  cscan_res_if res_ch ();

  cscan_disk_request_scheduler_top DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_ch),
    .res_o       (res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver either backs off at random or, once, holds off for a long stretch so that
  // the result register and the queue fill up and the scheduler stops taking items.
  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken   <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      res_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= rx_gap_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready) begin
      sched.compare_command(disk_cmd_t'{res_ch.kind, res_ch.cmd_track, res_ch.cmd_sector,
                                        res_ch.cmd_tag, res_ch.last});
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic request_t mk_req(int unsigned track, int unsigned first,
                                      int unsigned count, bit wr, int unsigned tag);
    request_t r;
    r.track    = TRACK_W'(track);
    r.first    = SECTOR_W'(first);
    r.count    = COUNT_W'(count);
    r.is_write = wr;
    r.tag      = TAG_W'(tag);
    return r;
  endfunction

  // Starting tracks mostly fall on the disk, so that most requests get into the store.
  function automatic request_t random_request();
    int unsigned span;
    int unsigned track;
    int unsigned count;
    span = sched.disk_tracks;
    if (span == 0 || span > 1024) begin
      span = 1024;
    end
    track = ($urandom_range(99) < 85) ? $urandom_range(span - 1) : $urandom_range(1023);
    count = ($urandom_range(99) < 70) ? $urandom_range(4) : $urandom_range(31);
    return mk_req(track, $urandom_range(15), count, $urandom_range(1), $urandom_range(255));
  endfunction

  task automatic offer(op_e op, request_t r);
    req_ch.valid            <= 1'b1;
    req_ch.op               <= op;
    req_ch.req_track        <= r.track;
    req_ch.req_first_sector <= r.first;
    req_ch.req_sector_count <= r.count;
    req_ch.req_is_write     <= r.is_write;
    req_ch.req_tag          <= r.tag;
    @(posedge clk);
    while (!req_ch.ready) begin
      @(posedge clk);
    end
    sched.take_item(op, r);
    sent++;
    while ($urandom_range(99) < tx_gap_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (sched.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_tracks(logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sched.set_tracks(value);
  endtask

  // Runs at the reset width of sixteen tracks with the arm on track 0.
  task automatic run_directed();
    offer(OP_DISPATCH, mk_req(0, 0, 0, 0, 0));
    offer(OP_ENQUEUE, mk_req(0, 0, 0, 0, 0));
    offer(OP_ENQUEUE, mk_req(15, 0, 1, 1, 255));
    offer(OP_ENQUEUE, mk_req(15, 15, 2, 0, 7));
    offer(OP_ENQUEUE, mk_req(1023, 15, 31, 1, 170));
    offer(OP_ENQUEUE, mk_req(3, 15, 31, 1, 1));
    offer(OP_ENQUEUE, mk_req(3, 0, 1, 0, 2));
    offer(OP_ENQUEUE, mk_req(8, 7, 9, 0, 3));
    offer(OP_DISPATCH, mk_req(0, 0, 0, 0, 0));
    offer(OP_DISPATCH, mk_req(1023, 15, 31, 1, 255));
    offer(OP_ENQUEUE, mk_req(2, 0, 4, 0, 4));
    offer(OP_ENQUEUE, mk_req(3, 5, 3, 1, 5));
    repeat (6) begin
      offer(OP_DISPATCH, mk_req(0, 0, 0, 0, 0));
    end
  endtask

  // Bursts of enqueues followed by bursts of dispatches, with a few stray items of the
  // other kind mixed in.
  task automatic run_random(int unsigned quota);
    int unsigned stop_at;
    int unsigned n_enq;
    int unsigned n_disp;
    stop_at = sent + quota;
    while (sent < stop_at) begin
      n_enq  = $urandom_range(18, 1);
      n_disp = $urandom_range(n_enq + 2, 1);
      repeat (n_enq) begin
        offer(($urandom_range(99) < 8) ? OP_DISPATCH : OP_ENQUEUE, random_request());
      end
      repeat (n_disp) begin
        offer(($urandom_range(99) < 8) ? OP_ENQUEUE : OP_DISPATCH, random_request());
      end
    end
  endtask

  initial begin
    sched                   = new();
    clk                     = 1'b0;
    rst_n                   = 1'b0;
    cfg_we                  = 1'b0;
    cfg_wdata               = '0;
    req_ch.valid            = 1'b0;
    req_ch.op               = OP_ENQUEUE;
    req_ch.req_track        = '0;
    req_ch.req_first_sector = '0;
    req_ch.req_sector_count = '0;
    req_ch.req_is_write     = 1'b0;
    req_ch.req_tag          = '0;
    res_ch.ready            = 1'b0;
    tx_gap_pct              = 12;
    rx_gap_pct              = 57;
    hold_req                = 1'b0;
    hold_taken              = 1'b0;
    hold_left               = 0;
    stall_cycles            = 0;
    sent                    = 0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 3) begin
        tx_gap_pct = 12;
        rx_gap_pct <= 57;
      end else if (p < 5) begin
        tx_gap_pct = 57;
        rx_gap_pct <= 12;
      end else begin
        tx_gap_pct = 0;
        rx_gap_pct <= 0;
      end
      write_tracks(TRACK_PLAN[p]);
      if (p == 5) begin
        hold_req <= 1'b1;
      end
      run_random(PHASE_ITEMS);
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sched.mismatches == 0 && sched.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
